/* design/uid_whitelist_table_macros.svh */
// Assertion macros for the whitelist table.
// Each check is clocked on clk and held off while rst_n is low.
`ifndef UID_WHITELIST_TABLE_MACROS_SVH
`define UID_WHITELIST_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define UWT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uwt check failed: same-cycle implication");
`define UWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uwt check failed: next-cycle implication");
`else
`define UWT_ASSERT_SAME(label, ante, cons)
`define UWT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/uwt_pkg.sv */
`default_nettype none

package uwt_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;

    // External field widths
    localparam int SLOT_W = 4;
    localparam int FILL_W = 5;

    // An erased entry holds all ones; that key is reserved
    localparam logic [KEY_W-1:0] ERASED_KEY = '1;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_INVALID   = 3'd5
    } status_t;

    typedef struct packed
    {
        op_t              operation;
        logic [KEY_W-1:0] key;
    } request_t;

    typedef struct packed
    {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [FILL_W-1:0] fill_count;
    } result_t;

    typedef logic [ENTRIES-1:0][KEY_W-1:0] key_array_t;

    // Priority match answer
    typedef struct packed
    {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } match_t;

    // Table write command
    typedef struct packed
    {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
    } table_wr_t;

endpackage

`default_nettype wire

/* design/uwt_match.sv */
`default_nettype none

module uwt_match
(
    input  wire uwt_pkg::key_array_t       keys,
    input  wire logic [uwt_pkg::KEY_W-1:0] key,
    output uwt_pkg::match_t                match
);
    import uwt_pkg::*;

    // Parallel compare, lowest matching index wins
    always_comb
    begin
        match = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (keys[i] == key)
            begin
                match.hit = 1'b1;
                match.idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

/* design/uwt_table.sv */
`default_nettype none

module uwt_table
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire uwt_pkg::table_wr_t        wr,
    output uwt_pkg::key_array_t            keys,
    output logic [uwt_pkg::CNT_W-1:0]      filled,
    output logic [uwt_pkg::CNT_W-1:0]      filled_after
);
    import uwt_pkg::*;

    key_array_t       keys_reg;
    logic [CNT_W-1:0] filled_reg;
    logic [CNT_W-1:0] filled_next;

    // Count of filled entries, saturating at the table size
    always_comb
    begin
        filled_next = filled_reg;
        if (wr.en && (filled_reg < CNT_W'(ENTRIES)))
        begin
            filled_next = filled_reg + CNT_W'(1);
        end
    end

    // Entry storage, erased at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                keys_reg[i] <= ERASED_KEY;
            end
            filled_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                keys_reg[wr.idx] <= wr.key;
            end
            filled_reg <= filled_next;
        end
    end

    assign keys         = keys_reg;
    assign filled       = filled_reg;
    assign filled_after = filled_next;

endmodule

`default_nettype wire

/* design/uid_whitelist_table.sv */
// uid_whitelist_table: whitelist of 32-bit card identifiers.
//
// Request channel: drive request (operation, key) and raise start; the
// transfer happens at the rising edge where start is high and busy is low.
// busy stays low, so one request can be issued on every cycle.
//
// Result channel: done is high for exactly one cycle and result carries
// status, slot and fill_count during that cycle. The receiver cannot stall.
//
// A request passes through the request register, then the parallel compare
// of all entries plus the priority encoders into the result register.
// Throughput is one request per cycle; a request sees every insert issued
// before it.
//
// Reset (rst_n low, asynchronous) erases all entries to all ones, clears
// the fill count and drops any request in flight.
`default_nettype none
`include "uid_whitelist_table_macros.svh"

module uid_whitelist_table
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire uwt_pkg::request_t request,
    output logic                   done,
    output uwt_pkg::result_t       result
);
    import uwt_pkg::*;

    logic             req_valid_reg;
    request_t         req_reg;
    logic             done_reg;
    result_t          result_reg;
    result_t          result_next;

    key_array_t       keys;
    logic [CNT_W-1:0] filled;
    logic [CNT_W-1:0] filled_after;
    match_t           key_match;
    match_t           free_match;
    table_wr_t        wr;
    logic             key_invalid;
    logic [31:0]      slot_wide;
    logic [31:0]      fill_wide;
    logic             insert_done;
    logic             no_slot_done;

    assign busy = 1'b0;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= request;
        end
    end

    // Storage and matchers
    uwt_table u_table
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .keys         (keys),
        .filled       (filled),
        .filled_after (filled_after)
    );

    uwt_match u_key_match
    (
        .keys  (keys),
        .key   (req_reg.key),
        .match (key_match)
    );

    uwt_match u_free_match
    (
        .keys  (keys),
        .key   (ERASED_KEY),
        .match (free_match)
    );

    // Decide the outcome and the table write
    always_comb
    begin
        key_invalid = (req_reg.key == ERASED_KEY);
        wr.en       = 1'b0;
        wr.idx      = free_match.idx;
        wr.key      = req_reg.key;
        slot_wide   = '0;
        result_next.status = ST_INVALID;

        if (key_invalid)
        begin
            result_next.status = ST_INVALID;
        end
        else if (req_reg.operation == OP_LOOKUP)
        begin
            if (key_match.hit)
            begin
                result_next.status = ST_FOUND;
                slot_wide          = 32'(key_match.idx);
            end
            else
            begin
                result_next.status = ST_NOT_FOUND;
            end
        end
        else if (key_match.hit)
        begin
            result_next.status = ST_DUPLICATE;
            slot_wide          = 32'(key_match.idx);
        end
        else if (!free_match.hit)
        begin
            result_next.status = ST_FULL;
        end
        else
        begin
            result_next.status = ST_INSERTED;
            slot_wide          = 32'(free_match.idx);
            wr.en              = req_valid_reg;
        end

        fill_wide              = 32'(filled_after);
        result_next.slot       = slot_wide[SLOT_W-1:0];
        result_next.fill_count = fill_wide[FILL_W-1:0];
    end

    // Result register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    assign insert_done  = done && (result.status == ST_INSERTED);
    assign no_slot_done = done && (result.status == ST_NOT_FOUND ||
                                   result.status == ST_FULL ||
                                   result.status == ST_INVALID);

    `UWT_ASSERT_NEXT(a_latency, start && !busy, req_valid_reg ##1 done)
    `UWT_ASSERT_SAME(a_fill_bound, 1'b1, filled <= CNT_W'(ENTRIES))
    `UWT_ASSERT_SAME(a_insert_counts, insert_done, filled == CNT_W'($past(filled) + CNT_W'(1)))
    `UWT_ASSERT_SAME(a_no_slot, no_slot_done, result.slot == '0)

endmodule

`default_nettype wire
